// File: hdl/nearest_remaining_point_select_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef NEAREST_REMAINING_POINT_SELECT_ASSERT_SVH
`define NEAREST_REMAINING_POINT_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NRPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrps assertion failed");

`endif

// File: hdl/nrps_pkg.sv
`timescale 1ns / 1ps

package nrps_pkg;

    // Fixed field widths of the words on both channels.
    localparam int TAG_W       = 16;
    localparam int OUT_COORD_W = 32;
    localparam int LEFT_W      = 9;

    // Latency of the distance pipeline in cycles.
    localparam int PIPE_LAT = 3;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic signed [OUT_COORD_W-1:0] coord_x;
        logic signed [OUT_COORD_W-1:0] coord_y;
        logic signed [OUT_COORD_W-1:0] coord_z;
        logic [TAG_W-1:0]              point_tag;
    } t_req;

    typedef struct packed {
        logic                          load_accepted;
        logic                          found;
        logic signed [OUT_COORD_W-1:0] sel_x;
        logic signed [OUT_COORD_W-1:0] sel_y;
        logic signed [OUT_COORD_W-1:0] sel_z;
        logic [TAG_W-1:0]              sel_tag;
        logic [LEFT_W-1:0]             points_left;
    } t_rsp;

endpackage

// File: hdl/nrps_if.sv
`timescale 1ns / 1ps

// Request channel: one word per load or query.
interface nrps_req_if import nrps_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Response channel: one word per request.
interface nrps_rsp_if import nrps_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/nrps_cell.sv
`timescale 1ns / 1ps

// One slot of the point ring. A direct write wins over the shift from
// the neighbor.
module nrps_cell #(
    parameter int DATA_W = 112
) (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_prev,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;

    // Slot contents.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_data <= i_wdata;
        end else if (i_shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;

endmodule

// File: hdl/nrps_dist.sv
`timescale 1ns / 1ps

// Three-stage squared distance pipeline: magnitudes, squares, sum.
// The point and its index travel alongside the arithmetic.
module nrps_dist import nrps_pkg::*; #(
    parameter int COORD_BITS = 32,
    parameter int IDX_W      = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic [3*COORD_BITS+TAG_W-1:0] i_pt,
    input  logic [3*COORD_BITS-1:0]   i_pos,
    output logic                      o_vld,
    output logic [IDX_W-1:0]          o_idx,
    output logic [3*COORD_BITS+TAG_W-1:0] o_pt,
    output logic [2*COORD_BITS+1:0]   o_dist
);

    localparam int CB = COORD_BITS;
    localparam int PW = 3*CB + TAG_W;
    localparam int SW = 2*CB;
    localparam int DW = 2*CB + 2;

    logic [CB-1:0] n_mag [3];
    logic [CB-1:0] r_mag [3];
    logic [SW-1:0] r_sq  [3];
    logic [DW-1:0] r_sum;

    logic [PIPE_LAT-1:0] r_vld;
    logic [IDX_W-1:0]    r_idx [PIPE_LAT];
    logic [PW-1:0]       r_pt  [PIPE_LAT];

    // Absolute coordinate differences, one per axis.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CB-1:0] pt_c;
        logic signed [CB-1:0] pos_c;
        logic signed [CB:0]   diff;

        assign pt_c  = i_pt[PW-1-a*CB -: CB];
        assign pos_c = i_pos[3*CB-1-a*CB -: CB];
        assign diff  = (CB+1)'(pt_c) - (CB+1)'(pos_c);
        assign n_mag[a] = diff[CB] ? CB'(-diff) : CB'(diff);
    end

    // Arithmetic stages.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_mag[a] <= n_mag[a];
            r_sq[a]  <= SW'(r_mag[a]) * SW'(r_mag[a]);
        end
        r_sum <= DW'(r_sq[0]) + DW'(r_sq[1]) + DW'(r_sq[2]);
    end

    // Side band carried along the stages.
    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_idx;
        r_pt[0]  <= i_pt;
        for (int s = 1; s < PIPE_LAT; s++) begin
            r_idx[s] <= r_idx[s-1];
            r_pt[s]  <= r_pt[s-1];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[PIPE_LAT-1];
    assign o_idx  = r_idx[PIPE_LAT-1];
    assign o_pt   = r_pt[PIPE_LAT-1];
    assign o_dist = r_sum;

endmodule

// File: hdl/nearest_remaining_point_select.sv
`timescale 1ns / 1ps

// Greedy nearest-point walk over a table of up to TABLE_DEPTH tagged 3-D
// points. A load word appends a point and clears the current selection;
// its response flags whether the table had room. A query word first drops
// the point chosen by the previous query (the last entry takes its slot),
// then returns the remaining point nearest to the given position, lowest
// index on ties, or found = 0 on an empty table. The points sit in a ring
// of cells that turns once per query, handing one point a cycle to a
// three-stage squared distance pipeline, so the time a query takes does
// not depend on the fill. Coordinates use the low COORD_BITS bits of
// each input, sign-extended.
module nearest_remaining_point_select import nrps_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nrps_req_if.sink   i_req,
    nrps_rsp_if.source o_rsp
);

    localparam int CB = COORD_BITS;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 3*CB + TAG_W;
    localparam int DW = 2*CB + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_chosen;
    logic          r_chosen_vld;
    logic [IW-1:0] r_step;
    logic [1:0]    r_drain;
    logic [3*CB-1:0] r_pos;
    logic [PW-1:0] r_last;
    logic          r_best_vld;
    logic [IW-1:0] r_best_idx;
    logic [DW-1:0] r_best_dist;
    logic [PW-1:0] r_best_pt;
    logic          r_ovalid;
    t_rsp          r_odata;

    logic          n_ovalid;
    logic          n_best_vld;
    t_rsp          n_odata;

    logic          out_free;
    logic          req_fire;
    logic          is_load;
    logic          full;
    logic          do_remove;
    logic [PW-1:0] in_pt;
    logic [PW-1:0] wr_data;
    logic [PW-1:0] cell_q [TABLE_DEPTH];
    logic [PW-1:0] head;
    logic          feed_vld;

    logic          pipe_vld;
    logic [IW-1:0] pipe_idx;
    logic [PW-1:0] pipe_pt;
    logic [DW-1:0] pipe_dist;

    logic signed [CB-1:0] best_x;
    logic signed [CB-1:0] best_y;
    logic signed [CB-1:0] best_z;

    // Handshake and request decode.
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign req_fire    = i_req.valid && i_req.ready;
    assign is_load     = i_req.data.req_type == REQ_LOAD;
    assign full        = r_count == CW'(TABLE_DEPTH);
    assign do_remove   = r_chosen_vld && (CW'(r_chosen) < r_count);
    assign in_pt       = {i_req.data.coord_x[CB-1:0], i_req.data.coord_y[CB-1:0],
                          i_req.data.coord_z[CB-1:0], i_req.data.point_tag};
    assign wr_data     = is_load ? in_pt : r_last;

    // Ring of point cells; slot 0 is the read head while the ring turns.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic wr;

        assign wr = req_fire && ((is_load && !full && (r_count[IW-1:0] == IW'(g))) ||
                                 (!is_load && do_remove && (r_chosen == IW'(g))));

        nrps_cell #(
            .DATA_W (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (r_state == ST_SCAN),
            .i_prev  (cell_q[(g + 1) % TABLE_DEPTH]),
            .i_wr    (wr),
            .i_wdata (wr_data),
            .o_data  (cell_q[g])
        );
    end

    assign head     = cell_q[0];
    assign feed_vld = (r_state == ST_SCAN) && (CW'(r_step) < r_count);

    // Distance pipeline fed from the ring head.
    nrps_dist #(
        .COORD_BITS (CB),
        .IDX_W      (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (feed_vld),
        .i_idx   (r_step),
        .i_pt    (head),
        .i_pos   (r_pos),
        .o_vld   (pipe_vld),
        .o_idx   (pipe_idx),
        .o_pt    (pipe_pt),
        .o_dist  (pipe_dist)
    );

    assign best_x = r_best_pt[PW-1 -: CB];
    assign best_y = r_best_pt[PW-1-CB -: CB];
    assign best_z = r_best_pt[TAG_W+CB-1 -: CB];

    // Next values of the response flags and the running-best flag.
    assign n_ovalid   = (req_fire && is_load) || ((r_state == ST_OUT) && out_free) ||
                        (r_ovalid && !o_rsp.ready);
    assign n_best_vld = (req_fire && !is_load) ? 1'b0 : (r_best_vld || pipe_vld);

    // Response word for a load in idle, or for a query when it leaves.
    always_comb begin
        n_odata = '0;
        if (r_state == ST_IDLE) begin
            n_odata.load_accepted = !full;
            n_odata.points_left   = full ? LEFT_W'(r_count) : LEFT_W'(r_count + CW'(1));
        end else begin
            n_odata.points_left = LEFT_W'(r_count);
            if (r_best_vld) begin
                n_odata.found   = 1'b1;
                n_odata.sel_x   = OUT_COORD_W'(best_x);
                n_odata.sel_y   = OUT_COORD_W'(best_y);
                n_odata.sel_z   = OUT_COORD_W'(best_z);
                n_odata.sel_tag = r_best_pt[TAG_W-1:0];
            end
        end
    end

    // Payload registers: query position, last entry, running best.
    always_ff @(posedge i_clk) begin
        if (req_fire && !is_load) begin
            r_pos <= in_pt[PW-1 -: 3*CB];
        end
        if (req_fire && is_load && !full) begin
            r_last <= in_pt;
        end else if (feed_vld && (CW'(r_step) + CW'(1) == r_count)) begin
            r_last <= head;
        end
        if (pipe_vld && (!r_best_vld || (pipe_dist < r_best_dist))) begin
            r_best_idx  <= pipe_idx;
            r_best_dist <= pipe_dist;
            r_best_pt   <= pipe_pt;
        end
    end

    // Sequencer, table bookkeeping and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_chosen     <= '0;
            r_chosen_vld <= 1'b0;
            r_step       <= '0;
            r_drain      <= '0;
            r_best_vld   <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_ovalid   <= n_ovalid;
            r_best_vld <= n_best_vld;
            case (r_state)
                ST_IDLE: begin
                    if (req_fire && is_load) begin
                        r_chosen_vld <= 1'b0;
                        r_odata      <= n_odata;
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end else if (req_fire) begin
                        if (do_remove) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_step  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_step <= r_step + IW'(1);
                    if (r_step == IW'(TABLE_DEPTH - 1)) begin
                        r_drain <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'(PIPE_LAT - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_odata      <= n_odata;
                        r_chosen_vld <= r_best_vld;
                        r_chosen     <= r_best_vld ? r_best_idx : '0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

endmodule

// File: hdl/nrps_checker.sv
`timescale 1ns / 1ps

`include "nearest_remaining_point_select_assert.svh"

// Port-level checks on the nearest point selector.
module nrps_checker import nrps_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    // A stalled response word stays put.
    `NRPS_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp))

    // A word answers either a load or a query, never both.
    `NRPS_ASSERT_IMP(a_kind_excl, i_clk, i_rst_n, i_rsp_valid, !(i_rsp.load_accepted && i_rsp.found))

    // Without a selection the selected point reads as zero.
    `NRPS_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp.found, i_rsp.sel_x == 0 && i_rsp.sel_y == 0 && i_rsp.sel_z == 0 && i_rsp.sel_tag == 0)

    // No new request is taken while a response is stuck.
    `NRPS_ASSERT_IMP(a_busy, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, !i_req_ready)

endmodule

bind nearest_remaining_point_select nrps_checker u_nrps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);
